>>> sv/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants for the ray/triangle intersection test
// Exact fixed-point widths of every pipeline quantity, outcome codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_W   = 32;              // Q15.16 coordinates
  localparam int FRAC_BITS = 16;
  localparam int TREG_W    = COORD_W - 1;     // t window registers
  localparam int EDGE_W    = COORD_W + 1;     // b-a, c-a, o-a
  localparam int PROD_W    = 2 * EDGE_W;      // 33x33 product
  localparam int CROSS_W   = PROD_W + 1;      // cross product component
  localparam int LO_W      = EDGE_W;          // low split of a cross component
  localparam int HI_W      = CROSS_W - LO_W;  // high split, signed
  localparam int PART_W    = EDGE_W + HI_W;   // dot partial product
  localparam int SCAL_W    = 104;             // det, un, vn, tn
  localparam int DET_EPS_SHIFT = 3 * FRAC_BITS - 23;
  localparam int CHUNK_W   = 26;              // det split for t window multiply
  localparam int NCHUNK    = SCAL_W / CHUNK_W;
  localparam int TPROD_W   = TREG_W + CHUNK_W;
  localparam int TSUM_W    = TREG_W + SCAL_W + 1;
  localparam int CMP_W     = TSUM_W + 1;
  localparam int CFG_IDX_W = 4;
  localparam int IN_W      = 9 * COORD_W;
  localparam int OUT_W     = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [TREG_W-1:0]  treg_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [SCAL_W-1:0]  scal_t;

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_PARALLEL = 3'd1,
    OC_U_OUT    = 3'd2,
    OC_V_OUT    = 3'd3,
    OC_T_OUT    = 3'd4
  } outcome_t;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_T_NEAR   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_T_FAR    = 4'd7;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t dx;
    coord_t dy;
    coord_t dz;
    treg_t  t_near;
    treg_t  t_far;
  } ray_t;

  typedef struct packed {
    scal_t det;
    scal_t un;
    scal_t vn;
    scal_t tn;
  } scalars_t;

endpackage

>>> sv/rti_cross.sv
// ----------------------------------------------------------------------------
// rti_cross: edges and cross products
// Three stages: edge/offset vectors, 33x33 products, cross differences.
// ----------------------------------------------------------------------------
module rti_cross (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rti_pkg::coord_t     a [3],
  input  rti_pkg::coord_t     b [3],
  input  rti_pkg::coord_t     c [3],
  input  rti_pkg::ray_t       ray,
  output logic                out_valid,
  output rti_pkg::edge_t      e1_o [3],
  output rti_pkg::edge_t      e2_o [3],
  output rti_pkg::edge_t      s_o  [3],
  output rti_pkg::cross_t     p_o  [3],
  output rti_pkg::cross_t     q_o  [3]
);

  localparam int PW = rti_pkg::PROD_W;

  rti_pkg::coord_t d [3];
  rti_pkg::coord_t o [3];

  logic           v1, v2;
  rti_pkg::edge_t e1_1 [3], e2_1 [3], s_1 [3];
  rti_pkg::edge_t e1_2 [3], e2_2 [3], s_2 [3];
  logic signed [PW-1:0] pm [6];
  logic signed [PW-1:0] qm [6];

  assign d[0] = ray.dx;
  assign d[1] = ray.dy;
  assign d[2] = ray.dz;
  assign o[0] = ray.ox;
  assign o[1] = ray.oy;
  assign o[2] = ray.oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1[i] <= rti_pkg::edge_t'(b[i]) - rti_pkg::edge_t'(a[i]);
        e2_1[i] <= rti_pkg::edge_t'(c[i]) - rti_pkg::edge_t'(a[i]);
        s_1[i]  <= rti_pkg::edge_t'(o[i]) - rti_pkg::edge_t'(a[i]);
      end
      // p = d x e2, q = s x e1: minuend/subtrahend pairs per component
      pm[0] <= d[1] * e2_1[2];  pm[1] <= d[2] * e2_1[1];
      pm[2] <= d[2] * e2_1[0];  pm[3] <= d[0] * e2_1[2];
      pm[4] <= d[0] * e2_1[1];  pm[5] <= d[1] * e2_1[0];
      qm[0] <= s_1[1] * e1_1[2]; qm[1] <= s_1[2] * e1_1[1];
      qm[2] <= s_1[2] * e1_1[0]; qm[3] <= s_1[0] * e1_1[2];
      qm[4] <= s_1[0] * e1_1[1]; qm[5] <= s_1[1] * e1_1[0];
      for (int i = 0; i < 3; i++) begin
        e1_2[i] <= e1_1[i];
        e2_2[i] <= e2_1[i];
        s_2[i]  <= s_1[i];
        e1_o[i] <= e1_2[i];
        e2_o[i] <= e2_2[i];
        s_o[i]  <= s_2[i];
        p_o[i]  <= rti_pkg::cross_t'(pm[2*i]) - rti_pkg::cross_t'(pm[2*i+1]);
        q_o[i]  <= rti_pkg::cross_t'(qm[2*i]) - rti_pkg::cross_t'(qm[2*i+1]);
      end
    end
  end

endmodule

>>> sv/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot: the four dot products det, un, vn, tn
// Cross components are split low/high so each multiply stays about 33x34;
// one stage of partial products, one stage of shifted sums.
// ----------------------------------------------------------------------------
module rti_dot (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rti_pkg::edge_t      e1 [3],
  input  rti_pkg::edge_t      e2 [3],
  input  rti_pkg::edge_t      s  [3],
  input  rti_pkg::cross_t     p  [3],
  input  rti_pkg::cross_t     q  [3],
  input  rti_pkg::ray_t       ray,
  output logic                out_valid,
  output rti_pkg::scalars_t   sc
);

  localparam int LW = rti_pkg::LO_W;
  localparam int HW = rti_pkg::HI_W;
  localparam int PW = rti_pkg::PART_W;
  localparam int SW = rti_pkg::SCAL_W;

  rti_pkg::edge_t d [3];
  logic signed [LW:0]   p_lo [3], q_lo [3];
  logic signed [HW-1:0] p_hi [3], q_hi [3];
  // index: 0 det, 1 un, 2 vn, 3 tn
  logic signed [PW-1:0] lo [4][3];
  logic signed [PW-1:0] hi [4][3];
  logic                 v4;
  rti_pkg::scal_t       acc [4];

  assign d[0] = rti_pkg::edge_t'(ray.dx);
  assign d[1] = rti_pkg::edge_t'(ray.dy);
  assign d[2] = rti_pkg::edge_t'(ray.dz);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_lo[i] = $signed({1'b0, p[i][LW-1:0]});
      q_lo[i] = $signed({1'b0, q[i][LW-1:0]});
      p_hi[i] = p[i][rti_pkg::CROSS_W-1:LW];
      q_hi[i] = q[i][rti_pkg::CROSS_W-1:LW];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = '0;
      for (int i = 0; i < 3; i++) begin
        acc[k] = acc[k] + (SW'(hi[k][i]) <<< LW) + SW'(lo[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lo[0][i] <= e1[i] * p_lo[i];
        hi[0][i] <= e1[i] * p_hi[i];
        lo[1][i] <= s[i]  * p_lo[i];
        hi[1][i] <= s[i]  * p_hi[i];
        lo[2][i] <= d[i]  * q_lo[i];
        hi[2][i] <= d[i]  * q_hi[i];
        lo[3][i] <= e2[i] * q_lo[i];
        hi[3][i] <= e2[i] * q_hi[i];
      end
      sc.det <= acc[0];
      sc.un  <= acc[1];
      sc.vn  <= acc[2];
      sc.tn  <= acc[3];
    end
  end

endmodule

>>> sv/rti_test.sv
// ----------------------------------------------------------------------------
// rti_test: division-free classification
// Stage 6 sign normalize and parallel test, stage 7 barycentric tests and
// t-bound partial products, stage 8 sums, stage 9 t compare and outcome.
// ----------------------------------------------------------------------------
module rti_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rti_pkg::scalars_t   sc,
  input  rti_pkg::ray_t       ray,
  output logic                out_valid,
  output rti_pkg::outcome_t   outcome
);

  localparam int SW = rti_pkg::SCAL_W;
  localparam int CW = rti_pkg::CHUNK_W;
  localparam int NC = rti_pkg::NCHUNK;
  localparam int TW = rti_pkg::TPROD_W;
  localparam int UW = rti_pkg::TSUM_W;
  localparam int MW = rti_pkg::CMP_W;
  localparam rti_pkg::scal_t EPS = SW'(1) <<< rti_pkg::DET_EPS_SHIFT;

  logic           v6, v7, v8;
  logic           par6, par7, par8;
  rti_pkg::scal_t adet, un6, vn6, tn6, tn7, tn8;
  logic           u7, vv7, u8, vv8;
  logic [TW-1:0]  lp [NC], hp [NC];
  logic [UW-1:0]  lsum, hsum, lsum_c, hsum_c;
  rti_pkg::scal_t uv;
  logic signed [MW-1:0] ts, lt, ht;
  logic           t_out;

  assign uv = un6 + vn6;

  always_comb begin
    lsum_c = '0;
    hsum_c = '0;
    for (int k = 0; k < NC; k++) begin
      lsum_c = lsum_c + (UW'(lp[k]) << (k * CW));
      hsum_c = hsum_c + (UW'(hp[k]) << (k * CW));
    end
  end

  assign ts    = MW'(tn8) <<< rti_pkg::FRAC_BITS;
  assign lt    = $signed({1'b0, lsum});
  assign ht    = $signed({1'b0, hsum});
  assign t_out = (ts <= lt) || (ts >= ht);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v6 <= in_valid;
      v7 <= v6;
      v8 <= v7;
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // normalize so det > 0
      par6 <= (sc.det < EPS) && (sc.det > -EPS);
      adet <= sc.det[SW-1] ? -sc.det : sc.det;
      un6  <= sc.det[SW-1] ? -sc.un  : sc.un;
      vn6  <= sc.det[SW-1] ? -sc.vn  : sc.vn;
      tn6  <= sc.det[SW-1] ? -sc.tn  : sc.tn;

      par7 <= par6;
      u7   <= un6[SW-1] || (un6 > adet);
      vv7  <= vn6[SW-1] || (uv > adet);
      tn7  <= tn6;
      for (int k = 0; k < NC; k++) begin
        lp[k] <= ray.t_near * adet[k*CW +: CW];
        hp[k] <= ray.t_far  * adet[k*CW +: CW];
      end

      par8 <= par7;
      u8   <= u7;
      vv8  <= vv7;
      tn8  <= tn7;
      lsum <= lsum_c;
      hsum <= hsum_c;

      if (par8)       outcome <= rti_pkg::OC_PARALLEL;
      else if (u8)    outcome <= rti_pkg::OC_U_OUT;
      else if (vv8)   outcome <= rti_pkg::OC_V_OUT;
      else if (t_out) outcome <= rti_pkg::OC_T_OUT;
      else            outcome <= rti_pkg::OC_HIT;
    end
  end

endmodule

>>> sv/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect: streaming ray/triangle hit test
// Exact fixed-point edge/cross/dot test of one triangle per beat against a
// ray held in configuration registers.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)
//  s_*       in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z (32b each)
//  m_*       out  tdata: hit[0], outcome[3:1], zero pad [7:4]
//  cfg_*     in   write: index 0..7 origin xyz, dir xyz, t_near, t_far
//
// Nine register stages, one beat per cycle sustained while m_tready allows;
// the depth is set by the cross-product and dot-product multiply stages and
// the t-window multiply. A stalled m_tready freezes the whole pipeline;
// s_tready = m_tready or an empty output register. Reset clears valid bits
// and loads the ray defaults (zero origin/direction, t_near 1, t_far max).
// Config writes only while idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rti_pkg::IN_W-1:0]       s_tdata,   // a_x..c_z
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rti_pkg::OUT_W-1:0]      m_tdata,   // hit, outcome, pad
  input  logic                           cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rti_pkg::COORD_W-1:0]    cfg_data
);

  localparam int CW = rti_pkg::COORD_W;

  rti_pkg::ray_t      ray;
  logic               en;
  rti_pkg::coord_t    a [3], b [3], c [3];
  logic               v3, v5;
  rti_pkg::edge_t     e1 [3], e2 [3], s [3];
  rti_pkg::cross_t    p [3], q [3];
  rti_pkg::scalars_t  sc;
  rti_pkg::outcome_t  outcome;

  // whole pipeline advances when the output register is free or drained
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = s_tdata[i*CW +: CW];
      b[i] = s_tdata[(i+3)*CW +: CW];
      c[i] = s_tdata[(i+6)*CW +: CW];
    end
  end

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ray.ox     <= '0;
      ray.oy     <= '0;
      ray.oz     <= '0;
      ray.dx     <= '0;
      ray.dy     <= '0;
      ray.dz     <= '0;
      ray.t_near <= rti_pkg::TREG_W'(1);
      ray.t_far  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_ORIGIN_X: ray.ox     <= cfg_data;
        rti_pkg::REG_ORIGIN_Y: ray.oy     <= cfg_data;
        rti_pkg::REG_ORIGIN_Z: ray.oz     <= cfg_data;
        rti_pkg::REG_DIR_X:    ray.dx     <= cfg_data;
        rti_pkg::REG_DIR_Y:    ray.dy     <= cfg_data;
        rti_pkg::REG_DIR_Z:    ray.dz     <= cfg_data;
        rti_pkg::REG_T_NEAR:   ray.t_near <= cfg_data[rti_pkg::TREG_W-1:0];
        rti_pkg::REG_T_FAR:    ray.t_far  <= cfg_data[rti_pkg::TREG_W-1:0];
        default: ;
      endcase
    end
  end

  // stages 1-3: edges, products, cross vectors p and q
  rti_cross u_cross (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .a(a), .b(b), .c(c), .ray(ray),
    .out_valid(v3), .e1_o(e1), .e2_o(e2), .s_o(s), .p_o(p), .q_o(q)
  );

  // stages 4-5: det, un, vn, tn
  rti_dot u_dot (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .e1(e1), .e2(e2), .s(s), .p(p), .q(q), .ray(ray),
    .out_valid(v5), .sc(sc)
  );

  // stages 6-9: classification; last stage is the output register
  rti_test u_test (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .sc(sc), .ray(ray),
    .out_valid(m_tvalid), .outcome(outcome)
  );

  assign m_tdata = {4'b0000, outcome, outcome == rti_pkg::OC_HIT};

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (m_tready || !m_tvalid))
    else $error("s_tready does not follow output register state");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == rti_pkg::OC_HIT)))
    else $error("hit flag disagrees with outcome");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:1] <= rti_pkg::OC_T_OUT && m_tdata[7:4] == 4'b0000))
    else $error("outcome code out of range");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for ray_triangle_intersect
// Streams triangles against a set of rays, predicts hit/outcome with an exact
// wide-integer Moller-Trumbore model and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rti_pkg::*;

  localparam int W = 200;  // wide enough for every exact product here
  typedef logic signed [W-1:0] big_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;   // hit, outcome[3:1], pad
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  ray_triangle_intersect i_dut (.*);

  // ray as the block should currently hold it
  coord_t ray_o[3];
  coord_t ray_d[3];
  treg_t  win_lo, win_hi;

  logic [3:0] pending_hits[$];  // {hit, outcome}
  int  errors;
  bit  src_idle_en, snk_idle_en;
  int  snk_hold;                // long sink stall, in cycles

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // exact classification of one triangle against the current ray
  function automatic logic [3:0] classify_tri(input logic [IN_W-1:0] tri_bits);
    big_t a[3], e1[3], e2[3], s[3], p[3], q[3], dv[3];
    big_t det, un, vn, tn, eps, ts;
    for (int i = 0; i < 3; i++) begin
      a[i]  = coord_t'(tri_bits[i*COORD_W +: COORD_W]);
      e1[i] = big_t'(coord_t'(tri_bits[(3+i)*COORD_W +: COORD_W])) - a[i];
      e2[i] = big_t'(coord_t'(tri_bits[(6+i)*COORD_W +: COORD_W])) - a[i];
      s[i]  = big_t'(ray_o[i]) - a[i];
      dv[i] = ray_d[i];
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = dv[(i+1)%3]*e2[(i+2)%3] - dv[(i+2)%3]*e2[(i+1)%3];
      q[i] = s[(i+1)%3]*e1[(i+2)%3] - s[(i+2)%3]*e1[(i+1)%3];
    end
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    eps = big_t'(1) <<< DET_EPS_SHIFT;
    if (det < eps && det > -eps) return {1'b0, OC_PARALLEL};
    un = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    vn = dv[0]*q[0] + dv[1]*q[1] + dv[2]*q[2];
    tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det) return {1'b0, OC_U_OUT};
    if (vn < 0 || un + vn > det) return {1'b0, OC_V_OUT};
    ts = tn <<< FRAC_BITS;
    if (ts <= big_t'({1'b0, win_lo}) * det) return {1'b0, OC_T_OUT};
    if (ts >= big_t'({1'b0, win_hi}) * det) return {1'b0, OC_T_OUT};
    return {1'b1, OC_HIT};
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      logic [3:0] want;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected beat %h", m_tdata));
      end else begin
        want = pending_hits.pop_front();
        if (m_tdata[0] !== want[3])
          report($sformatf("hit %b want %b", m_tdata[0], want[3]));
        if (m_tdata[3:1] !== want[2:0])
          report($sformatf("outcome %0d want %0d", m_tdata[3:1], want[2:0]));
        if (m_tdata[7:4] !== 4'd0) report("pad bits set");
      end
    end
  end

  // sink: random stall bursts, or a long hold when requested
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (snk_hold > 0) begin
        m_tready <= 1'b0;
        repeat (snk_hold) @(posedge clk);
        snk_hold = 0;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_tri(input logic [IN_W-1:0] tri_bits);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tri_bits;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_hits = {pending_hits, classify_tri(tri_bits)};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // one write beat; the caller drops cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X: ray_o[0] = val;
      REG_ORIGIN_Y: ray_o[1] = val;
      REG_ORIGIN_Z: ray_o[2] = val;
      REG_DIR_X:    ray_d[0] = val;
      REG_DIR_Y:    ray_d[1] = val;
      REG_DIR_Z:    ray_d[2] = val;
      REG_T_NEAR:   win_lo   = val[TREG_W-1:0];
      REG_T_FAR:    win_hi   = val[TREG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(input coord_t o[3], input coord_t d[3], input treg_t lo,
                         input treg_t hi);
    write_reg(REG_ORIGIN_X, o[0]);
    write_reg(REG_ORIGIN_Y, o[1]);
    write_reg(REG_ORIGIN_Z, o[2]);
    write_reg(REG_DIR_X, d[0]);
    write_reg(REG_DIR_Y, d[1]);
    write_reg(REG_DIR_Z, d[2]);
    write_reg(REG_T_NEAR, {1'($urandom_range(0, 1)), lo});  // top bit is ignored
    write_reg(REG_T_FAR, {1'($urandom_range(0, 1)), hi});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16
                      | ($urandom() & 32'h0000_ffff);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_tri(input coord_t v[9]);
    logic [IN_W-1:0] r;
    for (int i = 0; i < 9; i++) r[i*COORD_W +: COORD_W] = v[i];
    return r;
  endfunction

  // triangle with vertices scattered along and around the ray, well-formed so most tests go deep
  function automatic logic [IN_W-1:0] aimed_tri();
    coord_t v[9];
    int sc;
    sc = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 12);
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        v[k*3+i] = ray_o[i] + (ray_d[i] >>> 4) * $urandom_range(0, 64)
                   + 32'($signed($urandom_range(0, 2*sc)) - sc) * 32'sh1_0000
                   + ($urandom() & 32'h0fff);
    return pack_tri(v);
  endfunction

  function automatic logic [IN_W-1:0] noise_tri();
    coord_t v[9];
    for (int i = 0; i < 9; i++) v[i] = rnd_coord();
    return pack_tri(v);
  endfunction

  function automatic logic [IN_W-1:0] make_tri(input int ax, ay, az, bx, by, bz,
                                               cx, cy, cz);
    coord_t v[9];
    v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return pack_tri(v);
  endfunction

  localparam int ONE = 32'h1_0000;

  // reset defaults: zero direction, so everything is parallel
  task automatic test_reset_ray();
    send_tri(make_tri(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE));
    send_tri(noise_tri());
    drain();
  endtask

  task automatic test_directed();
    coord_t o[3], d[3];
    o = '{0, 0, 0};
    d = '{0, 0, ONE};
    set_ray(o, d, 1, 31'h7fff_ffff);
    // unit triangle in z=5: hit, edges on boundaries, each reject
    send_tri(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_tri(make_tri(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE));      // u=v=0 corner
    send_tri(make_tri(-ONE, 0, 5*ONE, 0, 0, 5*ONE, -ONE, ONE, 5*ONE));  // u=1 edge
    send_tri(make_tri(ONE, ONE, 5*ONE, 2*ONE, ONE, 5*ONE, ONE, 2*ONE, 5*ONE)); // u out
    send_tri(make_tri(-ONE, ONE, 5*ONE, 0, ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));   // v out
    send_tri(make_tri(-ONE, -ONE, -5*ONE, 2*ONE, -ONE, -5*ONE, -ONE, 2*ONE, -5*ONE));
    send_tri(make_tri(0, 0, 0, ONE, 0, 0, 0, 0, ONE));                  // parallel
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));                      // degenerate
    send_tri(make_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff));
    send_tri(make_tri(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_tri(~make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    // t exactly on the bounds, then an empty window
    set_ray(o, d, 5*ONE, 31'h7fff_ffff);
    send_tri(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    drain();
    set_ray(o, d, 0, 5*ONE);
    send_tri(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    send_tri(make_tri(-ONE, -ONE, 4*ONE, 2*ONE, -ONE, 4*ONE, -ONE, 2*ONE, 4*ONE));
    drain();
    set_ray(o, d, 31'h7fff_ffff, 0);
    send_tri(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    drain();
    // out-of-range index must not disturb the ray
    write_reg(4'd8, 32'hdead_beef);
    write_reg(4'd15, 32'h1234_5678);
    set_ray(o, d, 0, 0);
    send_tri(make_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE));
    drain();
  endtask

  task automatic test_random(input int rays, input int per_ray);
    coord_t o[3], d[3];
    treg_t lo, hi;
    for (int r = 0; r < rays; r++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = $urandom_range(0, 7) == 0 ? rnd_coord()
               : 32'($signed($urandom_range(0, 20)) - 10) * ONE + ($urandom() & 16'hffff);
        d[i] = $urandom_range(0, 7) == 0 ? rnd_coord()
               : 32'($signed($urandom_range(0, 8)) - 4) * ONE + ($urandom() & 16'hffff);
      end
      case ($urandom_range(0, 3))
        0: begin lo = '0; hi = 31'h7fff_ffff; end
        1: begin lo = treg_t'($urandom()); hi = treg_t'($urandom()); end
        default: begin
          lo = treg_t'($urandom_range(0, 8*ONE));
          hi = lo + treg_t'($urandom_range(1, 64*ONE));
        end
      endcase
      set_ray(o, d, lo, hi);
      for (int k = 0; k < per_ray; k++)
        send_tri($urandom_range(0, 4) == 0 ? noise_tri() : aimed_tri());
      drain();
    end
  endtask

  // sink holds off long enough for the pipeline to fill and block the source
  task automatic test_backpressure();
    snk_hold = 60;
    repeat (40) send_tri(aimed_tri());
    drain();
  endtask

  initial begin
    errors = 0; src_idle_en = 1; snk_idle_en = 1; snk_hold = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    ray_o = '{0, 0, 0}; ray_d = '{0, 0, 0};
    win_lo = 1; win_hi = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_ray();
    test_directed();
    test_backpressure();
    test_random(40, 35);
    src_idle_en = 0; snk_idle_en = 0;
    test_random(8, 30);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> sim.f
sv/rti_pkg.sv
sv/rti_cross.sv
sv/rti_dot.sv
sv/rti_test.sv
sv/ray_triangle_intersect.sv
bench/tb.sv
